// ===== rtl/mecanum_motion_command_mixer_top_defines.svh =====
// Assertion macros for the mecanum motion command mixer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef MECANUM_MOTION_COMMAND_MIXER_TOP_DEFINES_SVH
`define MECANUM_MOTION_COMMAND_MIXER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define MMCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define MMCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mmcm_pkg.sv =====
// Shared types, constants and the wheel direction table of the mixer.
// No dependencies; every file but the defines header imports it.
package mmcm_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned REQ_W   = 16;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned DUTY_W  = 10;
  localparam int unsigned PROD_W  = PCT_W + DUTY_W;

  typedef logic [PCT_W-1:0]  pct_t;
  typedef logic [DUTY_W-1:0] duty_t;
  typedef logic [PROD_W-1:0] prod_t;

  // Command kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR  = 2'd0,
    KIND_MODE  = 2'd1,
    KIND_SPEED = 2'd2,
    KIND_STOP  = 2'd3
  } kind_t;

  // Motion modes
  typedef enum logic [MODE_W-1:0] {
    MODE_STOP = 3'd0,
    MODE_FWD  = 3'd1,
    MODE_BWD  = 3'd2,
    MODE_LEFT = 3'd3,
    MODE_RIGHT = 3'd4,
    MODE_CCW  = 3'd5,
    MODE_CW   = 3'd6
  } mode_t;

  // Wheel directions
  typedef enum logic [1:0] {
    DIR_OFF = 2'd0,
    DIR_FWD = 2'd1,
    DIR_BWD = 2'd2
  } dir_t;

  typedef struct packed {
    dir_t fl;
    dir_t fr;
    dir_t rl;
    dir_t rr;
  } wheels_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_DUTY_START = 1'b0,
    REG_DUTY_MAX   = 1'b1
  } reg_idx_t;

  // Command characters
  localparam logic [CHAR_W-1:0] CHAR_FWD   = 8'h66; // f
  localparam logic [CHAR_W-1:0] CHAR_BWD   = 8'h62; // b
  localparam logic [CHAR_W-1:0] CHAR_LEFT  = 8'h6c; // l
  localparam logic [CHAR_W-1:0] CHAR_RIGHT = 8'h72; // r
  localparam logic [CHAR_W-1:0] CHAR_CCW   = 8'h71; // q
  localparam logic [CHAR_W-1:0] CHAR_CW    = 8'h65; // e
  localparam logic [CHAR_W-1:0] CHAR_STOP  = 8'h73; // s
  localparam logic [CHAR_W-1:0] CHAR_UP    = 8'h2b; // +
  localparam logic [CHAR_W-1:0] CHAR_DOWN  = 8'h2d; // -

  // Speed and duty constants
  localparam pct_t  PCT_FULL     = 7'd100;
  localparam pct_t  PCT_STEP     = 7'd5;
  localparam pct_t  PCT_STEP_TOP = 7'd95;
  localparam pct_t  PCT_RESET    = 7'd40;
  localparam duty_t DUTY_START_RESET = 10'd350;
  localparam duty_t DUTY_MAX_RESET   = 10'd999;

  // Divide by 100 as a multiply by ceil(2^24 / 100); exact for products below 2^17
  localparam int unsigned DIV_SHIFT = 24;
  localparam int unsigned RECIP_W   = 18;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100);

  // One command after the state update, carried to the duty pipeline
  typedef struct packed {
    mode_t mode;
    pct_t  speed;
    duty_t start;
    duty_t dmax;
    logic  status;
  } item_t;

  // Wheel directions for each motion mode
  function automatic wheels_t wheel_dirs(input mode_t mode);
    wheels_t w;
    w = '{DIR_OFF, DIR_OFF, DIR_OFF, DIR_OFF};
    case (mode)
      MODE_FWD:   w = '{DIR_FWD, DIR_FWD, DIR_FWD, DIR_FWD};
      MODE_BWD:   w = '{DIR_BWD, DIR_BWD, DIR_BWD, DIR_BWD};
      MODE_LEFT:  w = '{DIR_BWD, DIR_FWD, DIR_FWD, DIR_BWD};
      MODE_RIGHT: w = '{DIR_FWD, DIR_BWD, DIR_BWD, DIR_FWD};
      MODE_CCW:   w = '{DIR_BWD, DIR_FWD, DIR_BWD, DIR_FWD};
      MODE_CW:    w = '{DIR_FWD, DIR_BWD, DIR_FWD, DIR_BWD};
      default:    w = '{DIR_OFF, DIR_OFF, DIR_OFF, DIR_OFF};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/mmcm_if.sv =====
// Valid/ready channel interfaces for commands and results.
// Depends on mmcm_pkg for field widths and types.
interface mmcm_cmd_if;
  import mmcm_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CHAR_W-1:0]   command_char;
  logic [MODE_W-1:0]   motion_request;
  logic [REQ_W-1:0]    speed_request;

  modport source (output valid, kind, command_char, motion_request, speed_request,
                  input ready);
  modport sink (input valid, kind, command_char, motion_request, speed_request,
                output ready);
endinterface

interface mmcm_res_if;
  import mmcm_pkg::*;
  logic   valid;
  logic   ready;
  mode_t  motion_mode;
  pct_t   speed_percent;
  duty_t  duty;
  dir_t   front_left_dir;
  dir_t   front_right_dir;
  dir_t   rear_left_dir;
  dir_t   rear_right_dir;
  logic   status_report;

  modport source (output valid, motion_mode, speed_percent, duty, front_left_dir,
                  front_right_dir, rear_left_dir, rear_right_dir, status_report,
                  input ready);
  modport sink (input valid, motion_mode, speed_percent, duty, front_left_dir,
                front_right_dir, rear_left_dir, rear_right_dir, status_report,
                output ready);
endinterface

// ===== rtl/mmcm_state.sv =====
// Command decode, mode/speed state and the duty configuration registers.
// Depends on mmcm_pkg and mmcm_if; feeds one item word per command downstream.
module mmcm_state (
  input  logic                clk,
  input  logic                rst_n,
  mmcm_cmd_if.sink            in_cmd,
  input  logic                cfg_we,
  input  mmcm_pkg::reg_idx_t  cfg_index,
  input  mmcm_pkg::duty_t     cfg_data,
  output logic                item_valid,
  input  logic                item_ready,
  output mmcm_pkg::item_t     item
);
  import mmcm_pkg::*;

  duty_t duty_start_r;
  duty_t duty_max_r;
  mode_t mode_r,  mode_nxt;
  pct_t  speed_r, speed_nxt;
  duty_t start_r, start_nxt;
  duty_t dmax_r,  dmax_nxt;
  logic  status_nxt;
  item_t item_r;
  logic  item_valid_r;
  logic  accept;

  // Take a word when the item register is free or being drained
  assign in_cmd.ready = rst_n && (!item_valid_r || item_ready);
  assign accept       = in_cmd.valid && in_cmd.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_start_r <= DUTY_START_RESET;
      duty_max_r   <= DUTY_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DUTY_START: duty_start_r <= cfg_data;
        REG_DUTY_MAX:   duty_max_r   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Decode the command and compute the next state
  always_comb begin
    mode_nxt   = mode_r;
    speed_nxt  = speed_r;
    start_nxt  = start_r;
    dmax_nxt   = dmax_r;
    status_nxt = 1'b0;
    unique case (kind_t'(in_cmd.kind))
      KIND_CHAR: begin
        status_nxt = 1'b1;
        case (in_cmd.command_char)
          CHAR_FWD:   mode_nxt = MODE_FWD;
          CHAR_BWD:   mode_nxt = MODE_BWD;
          CHAR_LEFT:  mode_nxt = MODE_LEFT;
          CHAR_RIGHT: mode_nxt = MODE_RIGHT;
          CHAR_CCW:   mode_nxt = MODE_CCW;
          CHAR_CW:    mode_nxt = MODE_CW;
          CHAR_STOP:  mode_nxt = MODE_STOP;
          CHAR_UP: begin
            speed_nxt = (speed_r <= PCT_STEP_TOP) ? speed_r + PCT_STEP : PCT_FULL;
            start_nxt = duty_start_r;
            dmax_nxt  = duty_max_r;
          end
          CHAR_DOWN: begin
            speed_nxt = (speed_r >= PCT_STEP) ? speed_r - PCT_STEP : '0;
            start_nxt = duty_start_r;
            dmax_nxt  = duty_max_r;
          end
          default: status_nxt = 1'b0;
        endcase
      end
      KIND_MODE: begin
        if (in_cmd.motion_request <= MODE_CW) mode_nxt = mode_t'(in_cmd.motion_request);
        else mode_nxt = MODE_STOP;
      end
      KIND_SPEED: begin
        if (in_cmd.speed_request > REQ_W'(PCT_FULL)) speed_nxt = PCT_FULL;
        else speed_nxt = in_cmd.speed_request[PCT_W-1:0];
        start_nxt = duty_start_r;
        dmax_nxt  = duty_max_r;
      end
      KIND_STOP: mode_nxt = MODE_STOP;
      default:   ;
    endcase
  end

  // State registers; the duty range is captured whenever the speed is set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STOP;
      speed_r <= PCT_RESET;
      start_r <= DUTY_START_RESET;
      dmax_r  <= DUTY_MAX_RESET;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      speed_r <= speed_nxt;
      start_r <= start_nxt;
      dmax_r  <= dmax_nxt;
    end
  end

  // Item register toward the duty pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (accept) begin
      item_valid_r <= 1'b1;
    end else if (item_ready) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{mode: mode_nxt, speed: speed_nxt, start: start_nxt,
                  dmax: dmax_nxt, status: status_nxt};
    end
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/mmcm_duty.sv =====
// Duty mapping pipeline: span product, divide by 100, offset and clamp, result word.
// Depends on mmcm_pkg and mmcm_if.
module mmcm_duty (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  mmcm_pkg::item_t  item,
  mmcm_res_if.source       out_res
);
  import mmcm_pkg::*;

  localparam int unsigned MUL_W = PROD_W + RECIP_W;

  typedef struct packed {
    item_t item;
    prod_t prod;
  } s2_t;

  typedef struct packed {
    item_t item;
    duty_t quot;
  } s3_t;

  typedef struct packed {
    mode_t   mode;
    pct_t    speed;
    duty_t   duty;
    wheels_t dirs;
    logic    status;
  } res_t;

  logic v2_r, v3_r, v4_r;
  logic rdy2, rdy3, rdy4;
  s2_t  s2_r;
  s3_t  s3_r;
  res_t res_r, res_nxt;
  duty_t span;
  prod_t prod_nxt;
  logic [MUL_W-1:0]  scaled;
  logic [DUTY_W:0]   sum;
  duty_t duty_map;

  // Each stage moves when it is empty or its successor moves
  assign rdy4       = !v4_r || out_res.ready;
  assign rdy3       = !v3_r || rdy4;
  assign rdy2       = !v2_r || rdy3;
  assign item_ready = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= item_valid;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 2: speed times span, span zero when the range is inverted
  assign span     = (item.dmax >= item.start) ? item.dmax - item.start : '0;
  assign prod_nxt = PROD_W'(item.speed) * PROD_W'(span);

  always_ff @(posedge clk) begin
    if (rdy2 && item_valid) s2_r <= '{item: item, prod: prod_nxt};
  end

  // Stage 3: divide by 100 through the reciprocal
  assign scaled = MUL_W'(s2_r.prod) * MUL_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) s3_r <= '{item: s2_r.item, quot: scaled[DIV_SHIFT +: DUTY_W]};
  end

  // Stage 4: offset, clamp to max, zero for speed zero or stop
  assign sum = {1'b0, s3_r.item.start} + {1'b0, s3_r.quot};

  always_comb begin
    if (s3_r.item.speed == '0) duty_map = '0;
    else if (sum > {1'b0, s3_r.item.dmax}) duty_map = s3_r.item.dmax;
    else duty_map = sum[DUTY_W-1:0];
    res_nxt.mode   = s3_r.item.mode;
    res_nxt.speed  = s3_r.item.speed;
    res_nxt.duty   = (s3_r.item.mode == MODE_STOP) ? '0 : duty_map;
    res_nxt.dirs   = wheel_dirs(s3_r.item.mode);
    res_nxt.status = s3_r.item.status;
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) res_r <= res_nxt;
  end

  // Drive the result channel
  assign out_res.valid           = v4_r;
  assign out_res.motion_mode     = res_r.mode;
  assign out_res.speed_percent   = res_r.speed;
  assign out_res.duty            = res_r.duty;
  assign out_res.front_left_dir  = res_r.dirs.fl;
  assign out_res.front_right_dir = res_r.dirs.fr;
  assign out_res.rear_left_dir   = res_r.dirs.rl;
  assign out_res.rear_right_dir  = res_r.dirs.rr;
  assign out_res.status_report   = res_r.status;

endmodule

// ===== rtl/mecanum_motion_command_mixer_top.sv =====
// Top level of the mecanum motion command mixer.
// Depends on mmcm_pkg, mmcm_if, mmcm_state, mmcm_duty and the defines header.
//
// One command word in, one result word out. The block takes a command every
// cycle while the pipeline has room. An accepted command passes the item
// register and the duty stages before its result word becomes valid. The
// throughput of one word per cycle is set by the mode/speed state register,
// which updates at acceptance, while the duty mapping (span product, divide by
// 100 via reciprocal multiply, offset and clamp) runs in three further
// registered stages. The pipeline stages fill bubbles independently, so
// commands keep flowing while a result waits on the output, until four words
// are held inside. duty_start and duty_max are captured with the speed, so a
// new value takes effect at the next command that sets or steps the speed.
`include "mecanum_motion_command_mixer_top_defines.svh"

module mecanum_motion_command_mixer_top (
  input  logic                clk,
  input  logic                rst_n,
  mmcm_cmd_if.sink            in_cmd,
  mmcm_res_if.source          out_res,
  input  logic                cfg_we,
  input  mmcm_pkg::reg_idx_t  cfg_index,
  input  mmcm_pkg::duty_t     cfg_data
);
  import mmcm_pkg::*;

  logic  item_valid;
  logic  item_ready;
  item_t item;

  mmcm_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_cmd     (in_cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  mmcm_duty u_duty (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_res    (out_res)
  );

  // A stop command leaves a stopped item in the next cycle
  `MMCM_ASSERT_NEXT(a_stop_cmd, rst_n && in_cmd.valid && in_cmd.ready && in_cmd.kind == KIND_STOP, item_valid && item.mode == MODE_STOP, "stop command did not stop")

  // A stopped result drives no duty and no wheel
  `MMCM_ASSERT_NOW(a_stop_idle, out_res.valid && out_res.motion_mode == MODE_STOP, out_res.duty == '0 && out_res.front_left_dir == DIR_OFF && out_res.front_right_dir == DIR_OFF && out_res.rear_left_dir == DIR_OFF && out_res.rear_right_dir == DIR_OFF, "stopped result is driving")

  // Speed stays within percent range
  `MMCM_ASSERT_NOW(a_speed_range, out_res.valid, out_res.speed_percent <= PCT_FULL, "speed above full scale")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the mecanum motion command mixer: drives command words, tracks
// the expected mode, speed, duty and wheel directions, and checks each result word.
// Depends on mmcm_pkg, mmcm_if and the mecanum_motion_command_mixer_top RTL.
module tb_top;
  import mmcm_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 500;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_WORDS   = 100;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic [MODE_W-1:0] mode_req;
    logic [REQ_W-1:0]  speed_req;
  } cmd_word_t;

  typedef struct packed {
    mode_t   mode;
    pct_t    speed;
    duty_t   duty;
    wheels_t wheels;
    logic    status;
  } drive_word_t;

  // Tracks drive state and holds the result words still owed by the block
  class drive_tracker;
    duty_t       duty_start_reg;
    duty_t       duty_max_reg;
    mode_t       held_mode;
    pct_t        held_speed;
    duty_t       held_duty;
    drive_word_t owed_words[$];
    int unsigned commands_noted;
    int unsigned words_checked;
    int unsigned failures;

    function new();
      duty_start_reg = DUTY_START_RESET;
      duty_max_reg   = DUTY_MAX_RESET;
      held_mode      = MODE_STOP;
      commands_noted = 0;
      words_checked  = 0;
      failures       = 0;
      take_speed(PCT_RESET);
    endfunction

    function void set_register(reg_idx_t idx, duty_t val);
      if (idx == REG_DUTY_START) duty_start_reg = val;
      else duty_max_reg = val;
    endfunction

    // Map a speed percent onto the PWM compare range
    function duty_t duty_for_speed(pct_t pct);
      int unsigned span;
      int unsigned d;
      if (pct == 0) return '0;
      span = (duty_max_reg >= duty_start_reg) ? duty_max_reg - duty_start_reg : 0;
      d = duty_start_reg + (int'(pct) * span) / 100;
      if (d > duty_max_reg) d = duty_max_reg;
      return duty_t'(d);
    endfunction

    function void take_speed(pct_t pct);
      held_speed = pct;
      held_duty  = duty_for_speed(pct);
    endfunction

    function wheels_t wheels_for(mode_t m);
      wheels_t w;
      case (m)
        MODE_FWD:   w = '{DIR_FWD, DIR_FWD, DIR_FWD, DIR_FWD};
        MODE_BWD:   w = '{DIR_BWD, DIR_BWD, DIR_BWD, DIR_BWD};
        MODE_LEFT:  w = '{DIR_BWD, DIR_FWD, DIR_FWD, DIR_BWD};
        MODE_RIGHT: w = '{DIR_FWD, DIR_BWD, DIR_BWD, DIR_FWD};
        MODE_CCW:   w = '{DIR_BWD, DIR_FWD, DIR_BWD, DIR_FWD};
        MODE_CW:    w = '{DIR_FWD, DIR_BWD, DIR_FWD, DIR_BWD};
        default:    w = '{DIR_OFF, DIR_OFF, DIR_OFF, DIR_OFF};
      endcase
      return w;
    endfunction

    // Advance the drive state by one accepted command word
    function void note_command(cmd_word_t c);
      drive_word_t w;
      logic        status;
      status = 1'b0;
      commands_noted++;
      case (c.kind)
        KIND_CHAR: begin
          status = 1'b1;
          case (c.ch)
            CHAR_FWD:   held_mode = MODE_FWD;
            CHAR_BWD:   held_mode = MODE_BWD;
            CHAR_LEFT:  held_mode = MODE_LEFT;
            CHAR_RIGHT: held_mode = MODE_RIGHT;
            CHAR_CCW:   held_mode = MODE_CCW;
            CHAR_CW:    held_mode = MODE_CW;
            CHAR_STOP:  held_mode = MODE_STOP;
            CHAR_UP:
              take_speed(held_speed <= PCT_STEP_TOP ? held_speed + PCT_STEP : PCT_FULL);
            CHAR_DOWN:
              take_speed(held_speed >= PCT_STEP ? held_speed - PCT_STEP : pct_t'(0));
            default:    status = 1'b0;
          endcase
        end
        KIND_MODE:  held_mode = (c.mode_req <= 3'd6) ? mode_t'(c.mode_req) : MODE_STOP;
        KIND_SPEED: take_speed(c.speed_req > PCT_FULL ? PCT_FULL : pct_t'(c.speed_req));
        default:    held_mode = MODE_STOP;
      endcase
      w.mode   = held_mode;
      w.speed  = held_speed;
      w.duty   = (held_mode == MODE_STOP) ? duty_t'(0) : held_duty;
      w.wheels = wheels_for(held_mode);
      w.status = status;
      owed_words.push_back(w);
    endfunction

    function void flag(string field, logic [15:0] want, logic [15:0] got);
      failures++;
      if (failures <= 10)
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, field, want, got);
    endfunction

    // Compare one result word against the oldest owed word
    function void check_result(drive_word_t got);
      drive_word_t want;
      if (owed_words.size() == 0) begin
        flag("unexpected result word", 16'd0, 16'd1);
        return;
      end
      want = owed_words.pop_front();
      words_checked++;
      if (got.mode !== want.mode)           flag("motion_mode", want.mode, got.mode);
      if (got.speed !== want.speed)         flag("speed_percent", want.speed, got.speed);
      if (got.duty !== want.duty)           flag("duty", want.duty, got.duty);
      if (got.wheels.fl !== want.wheels.fl) flag("front_left_dir", want.wheels.fl, got.wheels.fl);
      if (got.wheels.fr !== want.wheels.fr) flag("front_right_dir", want.wheels.fr, got.wheels.fr);
      if (got.wheels.rl !== want.wheels.rl) flag("rear_left_dir", want.wheels.rl, got.wheels.rl);
      if (got.wheels.rr !== want.wheels.rr) flag("rear_right_dir", want.wheels.rr, got.wheels.rr);
      if (got.status !== want.status)       flag("status_report", want.status, got.status);
    endfunction

    function int unsigned owed();
      return owed_words.size();
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  logic           cfg_we;
  reg_idx_t       cfg_index;
  duty_t          cfg_data;
  bit             src_gaps;
  bit             sink_gaps;
  int unsigned    settings_run;
  int unsigned    quiet_cycles;
  drive_word_t    seen_word;
  drive_tracker   tracker;

  mmcm_cmd_if cmd_ch ();
  mmcm_res_if res_ch ();

  mecanum_motion_command_mixer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (cmd_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side in random bursts while sink_gaps is set
  initial begin
    forever begin
      if (sink_gaps && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      seen_word.mode      = res_ch.motion_mode;
      seen_word.speed     = res_ch.speed_percent;
      seen_word.duty      = res_ch.duty;
      seen_word.wheels.fl = res_ch.front_left_dir;
      seen_word.wheels.fr = res_ch.front_right_dir;
      seen_word.wheels.rl = res_ch.rear_left_dir;
      seen_word.wheels.rr = res_ch.rear_right_dir;
      seen_word.status    = res_ch.status_report;
      tracker.check_result(seen_word);
    end
  end

  // Abort when no word moves on either side for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

  function automatic cmd_word_t make_cmd(kind_t k, logic [CHAR_W-1:0] ch,
                                         logic [MODE_W-1:0] m, logic [REQ_W-1:0] s);
    cmd_word_t c;
    c.kind      = k;
    c.ch        = ch;
    c.mode_req  = m;
    c.speed_req = s;
    return c;
  endfunction

  // Mostly well-formed commands with random content, some noise bytes
  function automatic cmd_word_t random_command();
    cmd_word_t   c;
    int unsigned roll;
    c = make_cmd(KIND_CHAR, CHAR_W'($urandom), MODE_W'($urandom), REQ_W'($urandom));
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      case ($urandom_range(0, 8))
        0: c.ch = CHAR_FWD;
        1: c.ch = CHAR_BWD;
        2: c.ch = CHAR_LEFT;
        3: c.ch = CHAR_RIGHT;
        4: c.ch = CHAR_CCW;
        5: c.ch = CHAR_CW;
        6: c.ch = CHAR_STOP;
        7: c.ch = CHAR_UP;
        default: c.ch = CHAR_DOWN;
      endcase
    end else if (roll < 62) begin
      c.kind = KIND_CHAR;
    end else if (roll < 77) begin
      c.kind = KIND_MODE;
    end else if (roll < 92) begin
      c.kind = KIND_SPEED;
      case ($urandom_range(0, 9))
        0: c.speed_req = '0;
        1: c.speed_req = REQ_W'(PCT_FULL);
        2, 3: c.speed_req = REQ_W'($urandom);
        default: c.speed_req = REQ_W'($urandom_range(0, 100));
      endcase
    end else begin
      c.kind = KIND_STOP;
    end
    return c;
  endfunction

  // Present one command word and hold it until accepted
  task automatic send_command(cmd_word_t c);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    cmd_ch.valid          <= 1'b1;
    cmd_ch.kind           <= c.kind;
    cmd_ch.command_char   <= c.ch;
    cmd_ch.motion_request <= c.mode_req;
    cmd_ch.speed_request  <= c.speed_req;
    do @(posedge clk); while (!cmd_ch.ready);
    tracker.note_command(c);
  endtask

  // Drop valid and wait until every owed word has come back
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, duty_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(idx, val);
    @(posedge clk);
  endtask

  initial begin
    tracker      = new();
    settings_run = 0;
    src_gaps     = 1'b1;
    sink_gaps    = 1'b1;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_DUTY_START;
    cfg_data              <= '0;
    cmd_ch.valid          <= 1'b0;
    cmd_ch.kind           <= '0;
    cmd_ch.command_char   <= '0;
    cmd_ch.motion_request <= '0;
    cmd_ch.speed_request  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, every character, mode and speed corner cases
    send_command(make_cmd(KIND_CHAR, 8'h00, 3'd7, 16'hFFFF));
    send_command(make_cmd(KIND_CHAR, CHAR_FWD, 3'd0, 16'h0000));
    send_command(make_cmd(KIND_CHAR, CHAR_BWD, 3'd5, 16'h1234));
    send_command(make_cmd(KIND_CHAR, CHAR_LEFT, 3'd2, 16'h0064));
    send_command(make_cmd(KIND_CHAR, CHAR_RIGHT, 3'd1, 16'hFFFF));
    send_command(make_cmd(KIND_CHAR, CHAR_CCW, 3'd6, 16'h8000));
    send_command(make_cmd(KIND_CHAR, CHAR_CW, 3'd3, 16'h0001));
    send_command(make_cmd(KIND_CHAR, CHAR_UP, 3'd0, 16'h0000));
    send_command(make_cmd(KIND_CHAR, CHAR_DOWN, 3'd0, 16'h0000));
    send_command(make_cmd(KIND_CHAR, CHAR_STOP, 3'd0, 16'h0000));
    send_command(make_cmd(KIND_MODE, 8'hFF, MODE_RIGHT, 16'h0000));
    send_command(make_cmd(KIND_MODE, 8'h00, 3'd7, 16'h0000));
    send_command(make_cmd(KIND_MODE, 8'h00, MODE_FWD, 16'hFFFF));
    send_command(make_cmd(KIND_SPEED, 8'h66, 3'd0, 16'd0));
    send_command(make_cmd(KIND_CHAR, CHAR_DOWN, 3'd0, 16'd0));
    send_command(make_cmd(KIND_SPEED, 8'h00, 3'd7, 16'hFFFF));
    send_command(make_cmd(KIND_CHAR, CHAR_UP, 3'd0, 16'd0));
    send_command(make_cmd(KIND_SPEED, 8'h00, 3'd0, 16'd98));
    send_command(make_cmd(KIND_CHAR, CHAR_UP, 3'd0, 16'd0));
    send_command(make_cmd(KIND_SPEED, 8'h00, 3'd0, 16'd2));
    send_command(make_cmd(KIND_CHAR, CHAR_DOWN, 3'd0, 16'd0));
    send_command(make_cmd(KIND_SPEED, 8'h00, 3'd0, 16'd101));
    send_command(make_cmd(KIND_STOP, 8'hFF, 3'd7, 16'hFFFF));
    send_command(make_cmd(KIND_CHAR, 8'hFF, 3'd0, 16'd0));

    // Random phases, each behind a fresh register setting
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin write_register(REG_DUTY_START, 10'd0);    write_register(REG_DUTY_MAX, 10'd1023); end
        1: begin write_register(REG_DUTY_START, 10'd1023); write_register(REG_DUTY_MAX, 10'd0);    end
        2: begin write_register(REG_DUTY_START, 10'd0);    write_register(REG_DUTY_MAX, 10'd0);    end
        3: begin write_register(REG_DUTY_START, 10'd1023); write_register(REG_DUTY_MAX, 10'd1023); end
        4: begin
          write_register(REG_DUTY_START, duty_t'($urandom));
          write_register(REG_DUTY_MAX, duty_t'($urandom));
        end
        5: write_register(REG_DUTY_MAX, duty_t'($urandom));
        6: write_register(REG_DUTY_START, duty_t'($urandom));
        default: begin
          write_register(REG_DUTY_START, DUTY_START_RESET);
          write_register(REG_DUTY_MAX, DUTY_MAX_RESET);
        end
      endcase
      settings_run++;
      // Last phase runs flat out; others usually get random gaps on each side
      src_gaps  = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      sink_gaps = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      // A mode change first shows the duty held over from the old setting
      send_command(make_cmd(KIND_MODE, CHAR_W'($urandom), MODE_W'($urandom_range(1, 6)),
                            REQ_W'($urandom)));
      repeat (PHASE_WORDS - 1) send_command(random_command());
    end

    cmd_ch.valid <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run: %0d command words sent, %0d result words checked, %0d mismatches",
             tracker.commands_noted, tracker.words_checked, tracker.failures);
    $display("run: %0d register settings incl. zero, full and inverted duty spans",
             settings_run);
    if (tracker.failures == 0 && tracker.owed() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
